// ----- hdl/pfi_pkg.sv -----
package pfi_pkg;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [7:0]  dest;
        logic [31:0] stamp;
        logic [5:0]  size;
    } packet_t;

    localparam logic [1:0] KIND_HEAD = 2'd0;
    localparam logic [1:0] KIND_BODY = 2'd1;
    localparam logic [1:0] KIND_TAIL = 2'd2;

    localparam logic REG_OWN_NODE = 1'b0;
    localparam logic REG_OWN_HUB  = 1'b1;

    // 8-bit destinations always fit a 256-node network, so the wrap is an identity
    localparam int NODE_COUNT = 256;
    localparam int HUB_SHIFT  = 2;
    localparam logic [5:0] MAX_PACKET_FLITS = 6'd32;

endpackage

// ----- hdl/packet_flit_injector_abp_core.sv -----
// Network-on-chip source port with an alternating-bit handshake to the next hop.
// Each accepted item may offer one packet, which is queued in a QUEUE_DEPTH-entry
// packet memory or reported as dropped when the queue is full; in the same item,
// when ack_level equals the current request level and the queue holds a packet,
// one flit of the head packet is sent and req_level toggles. On accept in ST_IDLE,
// the offered packet is written and the head entry is read into a register;
// ST_EXEC then forms the flit from the registered read data (a packet
// pushed into an empty queue is forwarded around the memory). ST_EXEC waits
// while the previous result is still held in the output register.
module packet_flit_injector_abp_core
    import pfi_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,

    input  logic        item_valid,
    output logic        item_ready,
    input  logic        inject,
    input  logic [7:0]  dest_node,
    input  logic [31:0] packet_time,
    input  logic [5:0]  packet_flits,
    input  logic        ack_level,

    output logic        result_valid,
    input  logic        result_ready,
    output logic        flit_valid,
    output logic [7:0]  flit_source,
    output logic [7:0]  flit_dest,
    output logic [5:0]  flit_source_hub,
    output logic [5:0]  flit_dest_hub,
    output logic [31:0] flit_time,
    output logic [4:0]  flit_seq,
    output logic [1:0]  flit_kind,
    output logic        req_level,
    output logic        dropped
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    state_t state_reg, state_next;

    logic [7:0]       own_node_reg;
    logic [5:0]       own_hub_reg;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [5:0]       left_reg, left_next;
    logic             req_reg, req_next;
    logic             result_valid_reg, result_valid_next;

    logic    ack_reg;
    logic    drop_reg;
    logic    fwd_reg;
    packet_t fwd_entry_reg;
    packet_t rd_data_reg;
    packet_t mem [QUEUE_DEPTH];

    logic [7:0]  out_source_reg, out_dest_reg;
    logic [5:0]  out_source_hub_reg, out_dest_hub_reg;
    logic [31:0] out_time_reg;
    logic [4:0]  out_seq_reg;
    logic [1:0]  out_kind_reg;
    logic        out_flit_reg, out_req_reg, out_drop_reg;

    logic    accept;
    logic    push;
    logic    rd_en;
    logic    exec_fire;
    logic    send;
    packet_t wr_entry;
    packet_t head;
    logic [5:0] size_clamped;
    logic [5:0] left_cur;
    logic [5:0] left_dec;
    logic [5:0] seq_full;
    logic [1:0] kind;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!result_valid_reg || result_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        item_ready = 1'b0;
        exec_fire  = 1'b0;
        case (state_reg)
            ST_IDLE:
                item_ready = 1'b1;
            ST_EXEC:
                exec_fire = !result_valid_reg || result_ready;
            default:
            begin
                item_ready = 1'b0;
                exec_fire  = 1'b0;
            end
        endcase
    end

    assign accept = item_valid && item_ready;
    assign push   = accept && inject && (count_reg != CNT_FULL);
    assign rd_en  = accept;

    always_comb
    begin
        if (packet_flits == 6'd0)
            size_clamped = 6'd1;
        else if (packet_flits > MAX_PACKET_FLITS)
            size_clamped = MAX_PACKET_FLITS;
        else
            size_clamped = packet_flits;
    end

    assign wr_entry.dest  = dest_node;
    assign wr_entry.stamp = packet_time;
    assign wr_entry.size  = size_clamped;

    // packet memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_entry;
        if (rd_en)
            rd_data_reg <= mem[rd_ptr_reg];
    end

    assign head = fwd_reg ? fwd_entry_reg : rd_data_reg;
    assign send = exec_fire && (ack_reg == req_reg) && (count_reg != '0);

    always_comb
    begin
        if (left_reg == 6'd0 || left_reg > head.size)
            left_cur = head.size;
        else
            left_cur = left_reg;
        if (left_cur == head.size)
            kind = KIND_HEAD;
        else if (left_cur == 6'd1)
            kind = KIND_TAIL;
        else
            kind = KIND_BODY;
        seq_full = head.size - left_cur;
        left_dec = left_cur - 6'd1;
    end

    always_comb
    begin
        wr_ptr_next       = wr_ptr_reg;
        rd_ptr_next       = rd_ptr_reg;
        count_next        = count_reg;
        left_next         = left_reg;
        req_next          = req_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && result_ready)
            result_valid_next = 1'b0;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        if (exec_fire)
            result_valid_next = 1'b1;
        if (send)
        begin
            left_next = left_dec;
            req_next  = ~req_reg;
            if (left_dec == 6'd0)
            begin
                rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                count_next  = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            own_node_reg     <= '0;
            own_hub_reg      <= '0;
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            count_reg        <= '0;
            left_reg         <= '0;
            req_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_ptr_reg       <= rd_ptr_next;
            wr_ptr_reg       <= wr_ptr_next;
            count_reg        <= count_next;
            left_reg         <= left_next;
            req_reg          <= req_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OWN_NODE: own_node_reg <= cfg_data;
                    REG_OWN_HUB:  own_hub_reg  <= cfg_data[5:0];
                    default:      own_node_reg <= own_node_reg;
                endcase
            end
        end
    end

    // item capture; an empty queue means the head is the packet just written
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ack_reg       <= ack_level;
            drop_reg      <= inject && (count_reg == CNT_FULL);
            fwd_reg       <= push && (count_reg == '0);
            fwd_entry_reg <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            out_flit_reg       <= send;
            out_source_reg     <= send ? own_node_reg : 8'd0;
            out_dest_reg       <= send ? head.dest : 8'd0;
            out_source_hub_reg <= send ? own_hub_reg : 6'd0;
            out_dest_hub_reg   <= send ? head.dest[7:HUB_SHIFT] : 6'd0;
            out_time_reg       <= send ? head.stamp : 32'd0;
            out_seq_reg        <= send ? seq_full[4:0] : 5'd0;
            out_kind_reg       <= send ? kind : KIND_HEAD;
            out_req_reg        <= req_next;
            out_drop_reg       <= drop_reg;
        end
    end

    assign result_valid    = result_valid_reg;
    assign flit_valid      = out_flit_reg;
    assign flit_source     = out_source_reg;
    assign flit_dest       = out_dest_reg;
    assign flit_source_hub = out_source_hub_reg;
    assign flit_dest_hub   = out_dest_hub_reg;
    assign flit_time       = out_time_reg;
    assign flit_seq        = out_seq_reg;
    assign flit_kind       = out_kind_reg;
    assign req_level       = out_req_reg;
    assign dropped         = out_drop_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= MAX_PACKET_FLITS)
        else $error("flits left above packet limit");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && inject && (count_reg == CNT_FULL) |=> drop_reg && $stable(wr_ptr_reg))
        else $error("full queue accepted a packet");

    a_exec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) && result_valid_reg && !result_ready
        |=> (state_reg == ST_EXEC) && $stable(req_reg) && $stable(count_reg))
        else $error("item finished while result stalled");
`endif

endmodule

// ----- bench/packet_flit_injector_abp_core_test.sv -----
module packet_flit_injector_abp_core_test;
    import pfi_pkg::*;

    localparam int FIFO_DEPTH      = 16;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int PHASE_COUNT     = 8;
    localparam int HOLD_AT         = 500;
    localparam int LONG_HOLD       = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int MAX_REPORTS     = 10;
    localparam int DIR_ROWS        = 12;

    typedef struct packed {
        logic        inject;
        logic [7:0]  dest;
        logic [31:0] stamp;
        logic [5:0]  flits;
        logic        ack;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  source;
        logic [7:0]  dest;
        logic [5:0]  source_hub;
        logic [5:0]  dest_hub;
        logic [31:0] stamp;
        logic [4:0]  seq;
        logic [1:0]  kind;
        logic        req;
        logic        dropped;
    } flit_t;

    typedef struct packed {
        item_t it;
        logic  typed;
        flit_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        item_valid;
    logic        item_ready;
    logic        inject;
    logic [7:0]  dest_node;
    logic [31:0] packet_time;
    logic [5:0]  packet_flits;
    logic        ack_level;
    logic        result_valid;
    logic        result_ready;
    logic        flit_valid;
    logic [7:0]  flit_source;
    logic [7:0]  flit_dest;
    logic [5:0]  flit_source_hub;
    logic [5:0]  flit_dest_hub;
    logic [31:0] flit_time;
    logic [4:0]  flit_seq;
    logic [1:0]  flit_kind;
    logic        req_level;
    logic        dropped;

    packet_flit_injector_abp_core #(
        .QUEUE_DEPTH(FIFO_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .inject(inject),
        .dest_node(dest_node),
        .packet_time(packet_time),
        .packet_flits(packet_flits),
        .ack_level(ack_level),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .flit_valid(flit_valid),
        .flit_source(flit_source),
        .flit_dest(flit_dest),
        .flit_source_hub(flit_source_hub),
        .flit_dest_hub(flit_dest_hub),
        .flit_time(flit_time),
        .flit_seq(flit_seq),
        .flit_kind(flit_kind),
        .req_level(req_level),
        .dropped(dropped)
    );

    // predictor state
    packet_t     pkt_mem [FIFO_DEPTH];
    int unsigned fifo_rd;
    int unsigned fifo_wr;
    int unsigned fifo_cnt;
    logic [5:0]  head_left;
    logic        req_lvl;
    logic [7:0]  node_id;
    logic [5:0]  hub_id;

    flit_t due_flits [$];
    int    fault_count = 0;
    int    results_seen = 0;
    int    idle_cycles = 0;
    bit    src_calm;
    bit    sink_calm;
    bit    hold_done = 1'b0;

    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{'{1'b0, 8'h00, 32'h0000_0000, 6'd0, 1'b1}, 1'b1,
          '{1'b0, 8'h00, 8'h00, 6'h00, 6'h00, 32'h0, 5'd0, '0, 1'b0, 1'b0}},
        '{'{1'b0, 8'h12, 32'h0000_0042, 6'd5, 1'b0}, 1'b1,
          '{1'b0, 8'h00, 8'h00, 6'h00, 6'h00, 32'h0, 5'd0, '0, 1'b0, 1'b0}},
        '{'{1'b1, 8'hFF, 32'hFFFF_FFFF, 6'd0, 1'b0}, 1'b1,
          '{1'b1, 8'hA5, 8'hFF, 6'h2A, 6'h3F, 32'hFFFF_FFFF, 5'd0, KIND_HEAD, 1'b1, 1'b0}},
        '{'{1'b1, 8'h00, 32'h0000_0000, 6'd63, 1'b0}, 1'b1,
          '{1'b0, 8'h00, 8'h00, 6'h00, 6'h00, 32'h0, 5'd0, '0, 1'b1, 1'b0}},
        '{'{1'b0, 8'h00, 32'h0000_0000, 6'd0, 1'b1}, 1'b1,
          '{1'b1, 8'hA5, 8'h00, 6'h2A, 6'h00, 32'h0, 5'd0, KIND_HEAD, 1'b0, 1'b0}},
        '{'{1'b0, 8'h80, 32'h8000_0000, 6'd0, 1'b0}, 1'b0, '0},
        '{'{1'b1, 8'h55, 32'hAAAA_5555, 6'd1, 1'b1}, 1'b0, '0},
        '{'{1'b1, 8'hAA, 32'h5555_AAAA, 6'd32, 1'b0}, 1'b0, '0},
        '{'{1'b1, 8'h03, 32'h0000_0007, 6'd2, 1'b1}, 1'b0, '0},
        '{'{1'b1, 8'h04, 32'h0000_0008, 6'd33, 1'b0}, 1'b0, '0},
        '{'{1'b0, 8'h7F, 32'h7FFF_FFFF, 6'd31, 1'b0}, 1'b0, '0},
        '{'{1'b0, 8'h00, 32'h0000_0000, 6'd16, 1'b1}, 1'b0, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic flit_t forecast_flit(input item_t it);
        flit_t      r;
        packet_t    p;
        logic [5:0] n;
        logic [5:0] left;
        r = '0;
        if (it.inject)
        begin
            if (fifo_cnt >= FIFO_DEPTH)
                r.dropped = 1'b1;
            else
            begin
                n = it.flits;
                if (n == 0)
                    n = 6'd1;
                if (n > MAX_PACKET_FLITS)
                    n = MAX_PACKET_FLITS;
                pkt_mem[fifo_wr] = {it.dest, it.stamp, n};
                fifo_wr = (fifo_wr + 1) % FIFO_DEPTH;
                fifo_cnt++;
            end
        end
        if (it.ack == req_lvl && fifo_cnt > 0)
        begin
            p = pkt_mem[fifo_rd];
            left = head_left;
            if (left == 0 || left > p.size)
                left = p.size;
            if (left == p.size)
                r.kind = KIND_HEAD;
            else if (left == 1)
                r.kind = KIND_TAIL;
            else
                r.kind = KIND_BODY;
            r.valid = 1'b1;
            r.source = node_id;
            r.dest = p.dest;
            r.source_hub = hub_id;
            r.dest_hub = 6'(p.dest >> HUB_SHIFT);
            r.stamp = p.stamp;
            r.seq = 5'(p.size - left);
            left = left - 6'd1;
            if (left == 0)
            begin
                fifo_rd = (fifo_rd + 1) % FIFO_DEPTH;
                fifo_cnt--;
            end
            head_left = left;
            req_lvl = ~req_lvl;
        end
        r.req = req_lvl;
        return r;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic item_t make_item(input int send_pct, input int inject_pct);
        item_t it;
        int    r;
        it.inject = ($urandom_range(99) < inject_pct);
        it.dest = 8'($urandom);
        it.stamp = $urandom;
        r = $urandom_range(99);
        if (r < 70)
            it.flits = 6'($urandom_range(4, 1));
        else if (r < 85)
            it.flits = 6'($urandom_range(31, 5));
        else if (r < 90)
            it.flits = MAX_PACKET_FLITS;
        else if (r < 95)
            it.flits = 6'd0;
        else
            it.flits = 6'($urandom_range(63, 33));
        it.ack = ($urandom_range(99) < send_pct) ? req_lvl : ~req_lvl;
        return it;
    endfunction

    function automatic string flit_text(input flit_t f);
        return {$sformatf("v=%0d src=%02h dst=%02h shub=%0d dhub=%0d ",
                    f.valid, f.source, f.dest, f.source_hub, f.dest_hub),
                $sformatf("t=%08h seq=%0d kind=%0d req=%0d drop=%0d",
                    f.stamp, f.seq, f.kind, f.req, f.dropped)};
    endfunction

    function automatic string field_diff(input flit_t e, input flit_t g);
        string s;
        s = "";
        if (e.valid !== g.valid)           s = {s, " flit_valid"};
        if (e.source !== g.source)         s = {s, " flit_source"};
        if (e.dest !== g.dest)             s = {s, " flit_dest"};
        if (e.source_hub !== g.source_hub) s = {s, " flit_source_hub"};
        if (e.dest_hub !== g.dest_hub)     s = {s, " flit_dest_hub"};
        if (e.stamp !== g.stamp)           s = {s, " flit_time"};
        if (e.seq !== g.seq)               s = {s, " flit_seq"};
        if (e.kind !== g.kind)             s = {s, " flit_kind"};
        if (e.req !== g.req)               s = {s, " req_level"};
        if (e.dropped !== g.dropped)       s = {s, " dropped"};
        return s;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic offer_item(input item_t it, input logic typed, input flit_t want);
        int    gap;
        flit_t pred;
        gap = pick_gap(src_calm);
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        inject = it.inject;
        dest_node = it.dest;
        packet_time = it.stamp;
        packet_flits = it.flits;
        ack_level = it.ack;
        item_valid = 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        pred = forecast_flit(it);
        due_flits.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        if (idx == REG_OWN_NODE)
            node_id = value;
        else
            hub_id = value[5:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_drained();
        item_valid = 1'b0;
        while (due_flits.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // result side
    initial
    begin
        int gap;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                gap = LONG_HOLD;
            end
            else
                gap = pick_gap(sink_calm);
            if (gap > 0)
            begin
                result_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ready = 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        flit_t got;
        flit_t want;
        string diff;
        if (rst_n && result_valid && result_ready)
        begin
            got = {flit_valid, flit_source, flit_dest, flit_source_hub, flit_dest_hub,
                   flit_time, flit_seq, flit_kind, req_level, dropped};
            results_seen++;
            if (due_flits.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected item on result side: %s", flit_text(got));
            end
            else
            begin
                want = due_flits.pop_front();
                diff = field_diff(want, got);
                if (diff != "")
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("mismatch in%s\n  expected %s\n  actual   %s",
                            diff, flit_text(want), flit_text(got));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: %0d items still expected", due_flits.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        item_t      it;
        int         ph;
        int         send_pct;
        int         inject_pct;
        logic [7:0] node_val;
        logic [7:0] hub_val;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_OWN_NODE;
        cfg_data = 8'h00;
        item_valid = 1'b0;
        inject = 1'b0;
        dest_node = 8'h00;
        packet_time = 32'h0;
        packet_flits = 6'd0;
        ack_level = 1'b0;
        fifo_rd = 0;
        fifo_wr = 0;
        fifo_cnt = 0;
        head_left = 6'd0;
        req_lvl = 1'b0;
        node_id = 8'h00;
        hub_id = 6'h00;
        src_calm = 1'b0;
        sink_calm = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // hub write carries upper bits that must be dropped
        write_reg(REG_OWN_NODE, 8'hA5);
        write_reg(REG_OWN_HUB, 8'hEA);
        for (int i = 0; i < DIR_ROWS; i++)
            offer_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            wait_drained();
            case (ph)
                0:
                begin
                    node_val = 8'h00;
                    hub_val = 8'h00;
                end
                1:
                begin
                    node_val = 8'hFF;
                    hub_val = 8'hFF;
                end
                default:
                begin
                    node_val = 8'($urandom);
                    hub_val = 8'($urandom);
                end
            endcase
            write_reg(REG_OWN_NODE, node_val);
            write_reg(REG_OWN_HUB, hub_val);
            src_calm = (ph % 3 == 2);
            sink_calm = (ph % 4 == 1);
            case (ph % 4)
                0:
                begin
                    send_pct = 90;
                    inject_pct = 60;
                end
                1:
                begin
                    send_pct = 15;
                    inject_pct = 90;
                end
                2:
                begin
                    send_pct = 50;
                    inject_pct = 50;
                end
                default:
                begin
                    send_pct = 100;
                    inject_pct = 30;
                end
            endcase
            repeat (ITEMS_PER_PHASE)
            begin
                it = make_item(send_pct, inject_pct);
                offer_item(it, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (8) @(negedge clk);
        if (fault_count == 0 && due_flits.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- packet_flit_injector_abp_core.f -----
hdl/pfi_pkg.sv
hdl/packet_flit_injector_abp_core.sv
bench/packet_flit_injector_abp_core_test.sv
